[hw/rtl/eld_pkg.sv]
package eld_pkg;

  // Datapath widths
  localparam int unsigned YW  = 36;  // rotated offset, signed
  localparam int unsigned UW  = 35;  // rotated offset magnitude
  localparam int unsigned NW  = 30;  // normalised magnitude
  localparam int unsigned QW  = 61;  // radicand
  localparam int unsigned RW  = 31;  // root
  localparam int unsigned PW  = 31;  // scaled numerators
  localparam int unsigned CW  = 36;  // CORDIC x and y
  localparam int unsigned ZW  = 36;  // CORDIC angle accumulators
  localparam int unsigned SHW = 6;   // bit positions and shift counts

  localparam logic [ZW-1:0] HalfLn2  = 36'd372130559;
  localparam logic [ZW-1:0] AtanhSat = 36'd25769803776;

  localparam logic [31:0] CircTab [10] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149
  };
  localparam logic [31:0] HypTab [10] = '{
    32'd0, 32'd589812981, 32'd274247419, 32'd134923406, 32'd67196451,
    32'd33565361, 32'd16778582, 32'd8388779, 32'd4194325, 32'd2097155
  };

  typedef enum logic [2:0] {
    CFG_CENTER_X      = 3'd0,
    CFG_CENTER_Y      = 3'd1,
    CFG_COS_ANGLE     = 3'd2,
    CFG_SIN_ANGLE     = 3'd3,
    CFG_AXIS_RATIO_SQ = 3'd4,
    CFG_ELLIPTICITY   = 3'd5,
    CFG_DEFL_SCALE    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cosv;
    logic signed [31:0] sinv;
    logic [29:0]        f2;
    logic [30:0]        e;
    logic [30:0]        d;
  } cfg_t;

  // Per-point information that rides alongside the arithmetic
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               last;
    logic               centre;
    logic               s1;
    logic               s2;
    logic               hzero;
    logic               hsat;
  } side_t;

  // Position of the highest set bit, zero for an all-zero word
  function automatic logic [SHW-1:0] msb_pos(input logic [35:0] v);
    logic [SHW-1:0] p;
    p = '0;
    for (int i = 0; i < 36; i++) begin
      if (v[i]) p = SHW'(i);
    end
    return p;
  endfunction

  // Elementary angle for CORDIC step i, Q.30
  function automatic logic signed [ZW-1:0] angle_tab(input logic hyper, input int unsigned i);
    logic [63:0] t;
    t = '0;
    if (i < 10) begin
      t = hyper ? 64'(HypTab[i[3:0]]) : 64'(CircTab[i[3:0]]);
    end else if (i <= 62) begin
      t = ((64'd1 << 30) + (64'd1 << (i - 1))) >> i;
    end
    return $signed(t[ZW-1:0]);
  endfunction

  // Hyperbolic shift index for stage n, with steps 4, 13 and 40 repeated
  function automatic int unsigned hyp_index(input int unsigned n);
    int unsigned i;
    logic        rep;
    i   = 1;
    rep = 1'b0;
    for (int unsigned k = 0; k < n; k++) begin
      if (!rep && (i == 4 || i == 13 || i == 40)) begin
        rep = 1'b1;
      end else begin
        rep = 1'b0;
        i   = i + 1;
      end
    end
    return i;
  endfunction

endpackage

[hw/rtl/eld_front.sv]
module eld_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  eld_pkg::cfg_t          cfg_i,
  input  logic                   valid_i,
  input  logic signed [31:0]     px_i,
  input  logic signed [31:0]     py_i,
  input  logic                   last_i,
  output logic                   valid_o,
  output eld_pkg::side_t         side_o,
  output logic [eld_pkg::QW-1:0] q_o,
  output logic [eld_pkg::PW-1:0] p1_o,
  output logic [eld_pkg::PW-1:0] p2_o
);

  localparam int unsigned NS = 8;

  logic [NS-1:0]  v_q;
  eld_pkg::side_t side_q [NS];
  eld_pkg::side_t side0, side4;

  logic signed [32:0] dx_d, dy_d, dx_q, dy_q;
  logic [32:0] adx, ady;
  logic [31:0] acos, asin;
  logic [64:0] pa_q, pb_q, pc_q, pd_q;
  logic        sa_q, sb_q, sc_q, sd_q;
  logic [64:0] ta, tb, tc, td;
  logic signed [eld_pkg::YW-1:0] va, vb, vc, vd;
  logic signed [eld_pkg::YW-1:0] y1_q, y2_q;
  logic [eld_pkg::UW-1:0] u1_d, u2_d, u1_q, u2_q, mx;
  logic [eld_pkg::UW-1:0] w1_q, w2_q;
  logic [eld_pkg::SHW-1:0] pos_q;
  logic [63:0] sh1, sh2;
  logic [eld_pkg::NW-1:0] n1_q, n2_q;
  logic [59:0] sq1_q, sq2_q;
  logic [60:0] pe1_q, pe2_q;
  logic [60:0] re1, re2;
  logic [eld_pkg::QW-1:0] q_q;
  logic [eld_pkg::PW-1:0] p1_q, p2_q;

  // Sideband entering the pipe and its update once the signs are known
  always_comb begin
    side0      = '0;
    side0.px   = px_i;
    side0.py   = py_i;
    side0.last = last_i;
    side4        = side_q[2];
    side4.centre = (y1_q == '0) && (y2_q == '0);
    side4.s1     = y1_q[eld_pkg::YW-1];
    side4.s2     = y2_q[eld_pkg::YW-1];
  end

  // Offset from the centre
  assign dx_d = $signed({px_i[31], px_i}) - $signed({cfg_i.cx[31], cfg_i.cx});
  assign dy_d = $signed({py_i[31], py_i}) - $signed({cfg_i.cy[31], cfg_i.cy});

  // Magnitudes for the rotation products
  always_comb begin
    adx  = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
    ady  = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
    acos = cfg_i.cosv[31] ? 32'(-cfg_i.cosv) : 32'(cfg_i.cosv);
    asin = cfg_i.sinv[31] ? 32'(-cfg_i.sinv) : 32'(cfg_i.sinv);
  end

  // Round each product to nearest, ties away from zero, and form the rotated pair
  always_comb begin
    ta = pa_q + (65'd1 << 29);
    tb = pb_q + (65'd1 << 29);
    tc = pc_q + (65'd1 << 29);
    td = pd_q + (65'd1 << 29);
    va = sa_q ? -$signed({2'b00, ta[63:30]}) : $signed({2'b00, ta[63:30]});
    vb = sb_q ? -$signed({2'b00, tb[63:30]}) : $signed({2'b00, tb[63:30]});
    vc = sc_q ? -$signed({2'b00, tc[63:30]}) : $signed({2'b00, tc[63:30]});
    vd = sd_q ? -$signed({2'b00, td[63:30]}) : $signed({2'b00, td[63:30]});
  end

  // Magnitudes of the rotated offset, larger one and its leading bit
  always_comb begin
    u1_d = y1_q[eld_pkg::YW-1] ? eld_pkg::UW'(-y1_q) : eld_pkg::UW'(y1_q);
    u2_d = y2_q[eld_pkg::YW-1] ? eld_pkg::UW'(-y2_q) : eld_pkg::UW'(y2_q);
    mx   = (u1_q > u2_q) ? u1_q : u2_q;
  end

  // Normalise so that the larger magnitude has its top bit at 29
  always_comb begin
    if (pos_q >= eld_pkg::SHW'(29)) begin
      sh1 = 64'(w1_q) >> (pos_q - eld_pkg::SHW'(29));
      sh2 = 64'(w2_q) >> (pos_q - eld_pkg::SHW'(29));
    end else begin
      sh1 = 64'(w1_q) << (eld_pkg::SHW'(29) - pos_q);
      sh2 = 64'(w2_q) << (eld_pkg::SHW'(29) - pos_q);
    end
  end

  assign re1 = pe1_q + (61'd1 << 29);
  assign re2 = pe2_q + (61'd1 << 29);

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side0;
      for (int k = 1; k < NS; k++) begin
        side_q[k] <= (k == 3) ? side4 : side_q[k-1];
      end
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      pa_q  <= 65'(adx) * 65'(acos);
      pb_q  <= 65'(ady) * 65'(asin);
      pc_q  <= 65'(ady) * 65'(acos);
      pd_q  <= 65'(adx) * 65'(asin);
      sa_q  <= dx_q[32] ^ cfg_i.cosv[31];
      sb_q  <= dy_q[32] ^ cfg_i.sinv[31];
      sc_q  <= dy_q[32] ^ cfg_i.cosv[31];
      sd_q  <= dx_q[32] ^ cfg_i.sinv[31];
      y1_q  <= va - vb;
      y2_q  <= vc + vd;
      u1_q  <= u1_d;
      u2_q  <= u2_d;
      w1_q  <= u1_q;
      w2_q  <= u2_q;
      pos_q <= eld_pkg::msb_pos({1'b0, mx});
      n1_q  <= sh1[eld_pkg::NW-1:0];
      n2_q  <= sh2[eld_pkg::NW-1:0];
      sq1_q <= 60'(n1_q) * 60'(n1_q);
      sq2_q <= 60'(n2_q) * 60'(n2_q);
      pe1_q <= 61'(n1_q) * 61'(cfg_i.e);
      pe2_q <= 61'(n2_q) * 61'(cfg_i.e);
      q_q   <= 61'(sq1_q[59:30]) * 61'(cfg_i.f2) + 61'(sq2_q);
      p1_q  <= re1[60:30];
      p2_q  <= re2[60:30];
    end
  end

  assign valid_o = v_q[NS-1];
  assign side_o  = side_q[NS-1];
  assign q_o     = q_q;
  assign p1_o    = p1_q;
  assign p2_o    = p2_q;

endmodule

[hw/rtl/eld_sqrt.sv]
module eld_sqrt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  eld_pkg::side_t         side_i,
  input  logic [eld_pkg::QW-1:0] q_i,
  input  logic [eld_pkg::PW-1:0] p1_i,
  input  logic [eld_pkg::PW-1:0] p2_i,
  output logic                   valid_o,
  output eld_pkg::side_t         side_o,
  output logic [eld_pkg::RW-1:0] r_o,
  output logic [eld_pkg::PW-1:0] p1_o,
  output logic [eld_pkg::PW-1:0] p2_o
);

  localparam int unsigned RW = eld_pkg::RW;
  localparam int unsigned XW = eld_pkg::QW + 1;

  logic                   v_q    [RW];
  eld_pkg::side_t         side_q [RW];
  logic [XW-1:0]          rem_q  [RW];
  logic [RW-1:0]          root_q [RW];
  logic [eld_pkg::PW-1:0] p1_q   [RW];
  logic [eld_pkg::PW-1:0] p2_q   [RW];

  // One root bit per stage, most significant first
  for (genvar g = 0; g < RW; g++) begin : g_bit
    localparam int unsigned B = RW - 1 - g;

    logic                   v_in;
    eld_pkg::side_t         side_in;
    logic [XW-1:0]          rem_in, trial;
    logic [RW-1:0]          root_in;
    logic [eld_pkg::PW-1:0] p1_in, p2_in;

    if (g == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign rem_in  = {1'b0, q_i};
      assign root_in = '0;
      assign p1_in   = p1_i;
      assign p2_in   = p2_i;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign side_in = side_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign p1_in   = p1_q[g-1];
      assign p2_in   = p2_q[g-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = (XW'(root_in) << (B + 1)) + (XW'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[g] <= side_in;
        p1_q[g]   <= p1_in;
        p2_q[g]   <= p2_in;
        if (rem_in >= trial) begin
          rem_q[g]  <= rem_in - trial;
          root_q[g] <= root_in | (RW'(1) << B);
        end else begin
          rem_q[g]  <= rem_in;
          root_q[g] <= root_in;
        end
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign side_o  = side_q[RW-1];
  assign r_o     = root_q[RW-1];
  assign p1_o    = p1_q[RW-1];
  assign p2_o    = p2_q[RW-1];

endmodule

[hw/rtl/eld_cordic.sv]
module eld_cordic #(
  parameter int unsigned STAGES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  eld_pkg::side_t                side_i,
  input  logic [eld_pkg::RW-1:0]        r_i,
  input  logic [eld_pkg::PW-1:0]        p1_i,
  input  logic [eld_pkg::PW-1:0]        p2_i,
  output logic                          valid_o,
  output eld_pkg::side_t                side_o,
  output logic signed [eld_pkg::ZW-1:0] zc_o,
  output logic signed [eld_pkg::ZW-1:0] zh_o
);

  localparam int unsigned CW  = eld_pkg::CW;
  localparam int unsigned ZW  = eld_pkg::ZW;
  localparam int unsigned SHW = eld_pkg::SHW;

  // Set-up stages for the hyperbolic path
  logic [2:0]     pv_q;
  eld_pkg::side_t pside_q [3];
  eld_pkg::side_t side1;
  logic [31:0] a1_q, b1_q, a2_q;
  logic [SHW-1:0] la_q, lb_q, k_q, dsh;
  logic [33:0] bs, bk_d, bk_q;
  logic [SHW-1:0] k_d;
  logic [eld_pkg::RW-1:0] rc1_q, rc2_q;
  logic [eld_pkg::PW-1:0] pc1_q, pc2_q;

  // Rotation stages; entry 0 is the last set-up register
  logic                 v_q    [STAGES+1];
  eld_pkg::side_t       side_q [STAGES+1];
  logic signed [CW-1:0] xc_q   [STAGES+1];
  logic signed [CW-1:0] yc_q   [STAGES+1];
  logic signed [ZW-1:0] zc_q   [STAGES+1];
  logic signed [CW-1:0] xh_q   [STAGES+1];
  logic signed [CW-1:0] yh_q   [STAGES+1];
  logic signed [ZW-1:0] zh_q   [STAGES+1];

  // Special cases of the atanh argument
  always_comb begin
    side1       = side_i;
    side1.hzero = (p2_i == '0);
    side1.hsat  = (32'(p2_i) >= 32'(r_i));
  end

  // Double B until the next doubling would pass A
  always_comb begin
    dsh = (la_q > lb_q) ? (la_q - lb_q) : '0;
    bs  = 34'(b1_q) << dsh;
    if (bs <= 34'(a1_q)) begin
      k_d  = dsh;
      bk_d = bs;
    end else begin
      k_d  = dsh - SHW'(1);
      bk_d = bs >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= '0;
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      pv_q   <= {pv_q[1:0], valid_i};
      v_q[0] <= pv_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pside_q[0] <= side1;
      pside_q[1] <= pside_q[0];
      side_q[0]  <= pside_q[1];
      a1_q  <= 32'(r_i) + 32'(p2_i);
      b1_q  <= 32'(r_i) - 32'(p2_i);
      la_q  <= eld_pkg::msb_pos({4'b0, 32'(r_i) + 32'(p2_i)});
      lb_q  <= eld_pkg::msb_pos({4'b0, 32'(r_i) - 32'(p2_i)});
      rc1_q <= r_i;
      pc1_q <= p1_i;
      a2_q  <= a1_q;
      bk_q  <= bk_d;
      k_q   <= k_d;
      rc2_q <= rc1_q;
      pc2_q <= pc1_q;
      xc_q[0] <= $signed(CW'(rc2_q));
      yc_q[0] <= $signed(CW'(pc2_q));
      zc_q[0] <= '0;
      xh_q[0] <= $signed(CW'(a2_q) + CW'(bk_q));
      yh_q[0] <= $signed(CW'(a2_q) - CW'(bk_q));
      zh_q[0] <= $signed(ZW'(k_q) * eld_pkg::HalfLn2);
    end
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    localparam int unsigned HI = eld_pkg::hyp_index(g);
    localparam logic signed [ZW-1:0] CA = eld_pkg::angle_tab(1'b0, g);
    localparam logic signed [ZW-1:0] HA = eld_pkg::angle_tab(1'b1, HI);

    logic signed [CW-1:0] xcs, ycs, xhs, yhs;

    assign xcs = xc_q[g] >>> g;
    assign ycs = yc_q[g] >>> g;
    assign xhs = xh_q[g] >>> HI;
    assign yhs = yh_q[g] >>> HI;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g+1] <= 1'b0;
      end else if (en_i) begin
        v_q[g+1] <= v_q[g];
      end
    end

    // Drive y towards zero on both paths
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[g+1] <= side_q[g];
        if (!yc_q[g][CW-1]) begin
          xc_q[g+1] <= xc_q[g] + ycs;
          yc_q[g+1] <= yc_q[g] - xcs;
          zc_q[g+1] <= zc_q[g] + CA;
        end else begin
          xc_q[g+1] <= xc_q[g] - ycs;
          yc_q[g+1] <= yc_q[g] + xcs;
          zc_q[g+1] <= zc_q[g] - CA;
        end
        if (!yh_q[g][CW-1]) begin
          xh_q[g+1] <= xh_q[g] - yhs;
          yh_q[g+1] <= yh_q[g] - xhs;
          zh_q[g+1] <= zh_q[g] + HA;
        end else begin
          xh_q[g+1] <= xh_q[g] + yhs;
          yh_q[g+1] <= yh_q[g] + xhs;
          zh_q[g+1] <= zh_q[g] - HA;
        end
      end
    end
  end

  assign valid_o = v_q[STAGES];
  assign side_o  = side_q[STAGES];
  assign zc_o    = zc_q[STAGES];
  assign zh_o    = zh_q[STAGES];

endmodule

[hw/rtl/eld_back.sv]
module eld_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  eld_pkg::cfg_t                 cfg_i,
  input  logic                          valid_i,
  input  eld_pkg::side_t                side_i,
  input  logic signed [eld_pkg::ZW-1:0] zc_i,
  input  logic signed [eld_pkg::ZW-1:0] zh_i,
  output logic                          valid_o,
  output logic signed [31:0]            sx_o,
  output logic signed [31:0]            sy_o,
  output logic                          centre_o,
  output logic                          last_o
);

  localparam int unsigned NS = 6;
  localparam int unsigned TW = 38;  // scaled angle magnitude
  localparam int unsigned FW = 41;  // deflection term, signed
  localparam int unsigned DW = 43;  // point minus deflection, signed

  logic [NS-1:0]  v_q;
  eld_pkg::side_t side_q [NS-1];

  logic signed [eld_pkg::ZW-1:0] hy;
  logic [35:0] mth, mhy;
  logic [48:0] pl1_q, ph1_q, pl2_q, ph2_q;
  logic        g1_q, g2_q, g1b_q, g2b_q;
  logic [67:0] s1w, s2w;
  logic [TW-1:0] m1_q, m2_q;
  logic [31:0] acos, asin;
  logic [50:0] pah_q, pal_q, pbh_q, pbl_q, pch_q, pcl_q, pdh_q, pdl_q;
  logic        sa_q, sb_q, sc_q, sd_q;
  logic [70:0] ra, rb, rc, rd;
  logic signed [FW-1:0] ta_q, tb_q, tc_q, td_q;
  logic signed [DW-1:0] dfx_q, dfy_q;

  // Apply the special cases and the signs of the rotated offset
  always_comb begin
    if (side_i.hzero) begin
      hy = '0;
    end else if (side_i.hsat) begin
      hy = $signed(eld_pkg::AtanhSat);
    end else begin
      hy = zh_i;
    end
    mth = zc_i[eld_pkg::ZW-1] ? 36'(-zc_i) : 36'(zc_i);
    mhy = hy[eld_pkg::ZW-1] ? 36'(-hy) : 36'(hy);
  end

  // Recombine partial products and round
  always_comb begin
    s1w = 68'({ph1_q, 18'b0}) + 68'(pl1_q) + (68'd1 << 29);
    s2w = 68'({ph2_q, 18'b0}) + 68'(pl2_q) + (68'd1 << 29);
    acos = cfg_i.cosv[31] ? 32'(-cfg_i.cosv) : 32'(cfg_i.cosv);
    asin = cfg_i.sinv[31] ? 32'(-cfg_i.sinv) : 32'(cfg_i.sinv);
    ra = 71'({pah_q, 19'b0}) + 71'(pal_q) + (71'd1 << 29);
    rb = 71'({pbh_q, 19'b0}) + 71'(pbl_q) + (71'd1 << 29);
    rc = 71'({pch_q, 19'b0}) + 71'(pcl_q) + (71'd1 << 29);
    rd = 71'({pdh_q, 19'b0}) + 71'(pdl_q) + (71'd1 << 29);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < NS - 1; k++) begin
        side_q[k] <= side_q[k-1];
      end
      // Scale by the deflection factor
      pl1_q <= 49'(mth[17:0]) * 49'(cfg_i.d);
      ph1_q <= 49'(mth[35:18]) * 49'(cfg_i.d);
      pl2_q <= 49'(mhy[17:0]) * 49'(cfg_i.d);
      ph2_q <= 49'(mhy[35:18]) * 49'(cfg_i.d);
      g1_q  <= zc_i[eld_pkg::ZW-1] ^ side_i.s1;
      g2_q  <= hy[eld_pkg::ZW-1] ^ side_i.s2;
      m1_q  <= s1w[67:30];
      m2_q  <= s2w[67:30];
      g1b_q <= g1_q;
      g2b_q <= g2_q;
      // Rotate back
      pah_q <= 51'(m1_q[37:19]) * 51'(acos);
      pal_q <= 51'(m1_q[18:0]) * 51'(acos);
      pbh_q <= 51'(m2_q[37:19]) * 51'(asin);
      pbl_q <= 51'(m2_q[18:0]) * 51'(asin);
      pch_q <= 51'(m2_q[37:19]) * 51'(acos);
      pcl_q <= 51'(m2_q[18:0]) * 51'(acos);
      pdh_q <= 51'(m1_q[37:19]) * 51'(asin);
      pdl_q <= 51'(m1_q[18:0]) * 51'(asin);
      sa_q  <= g1b_q ^ cfg_i.cosv[31];
      sb_q  <= g2b_q ^ cfg_i.sinv[31];
      sc_q  <= g2b_q ^ cfg_i.cosv[31];
      sd_q  <= g1b_q ^ cfg_i.sinv[31];
      ta_q  <= sa_q ? -$signed({1'b0, ra[69:30]}) : $signed({1'b0, ra[69:30]});
      tb_q  <= sb_q ? -$signed({1'b0, rb[69:30]}) : $signed({1'b0, rb[69:30]});
      tc_q  <= sc_q ? -$signed({1'b0, rc[69:30]}) : $signed({1'b0, rc[69:30]});
      td_q  <= sd_q ? -$signed({1'b0, rd[69:30]}) : $signed({1'b0, rd[69:30]});
      // Subtract the deflection from the point
      dfx_q <= DW'(side_q[3].px) - DW'(ta_q) - DW'(tb_q);
      dfy_q <= DW'(side_q[3].py) - DW'(tc_q) + DW'(td_q);
      // Saturate, or pass the point through at the centre
      centre_o <= side_q[4].centre;
      last_o   <= side_q[4].last;
      if (side_q[4].centre) begin
        sx_o <= side_q[4].px;
        sy_o <= side_q[4].py;
      end else begin
        if (dfx_q > DW'(32'sh7FFFFFFF)) begin
          sx_o <= 32'sh7FFFFFFF;
        end else if (dfx_q < DW'(-33'sd2147483648)) begin
          sx_o <= 32'sh80000000;
        end else begin
          sx_o <= dfx_q[31:0];
        end
        if (dfy_q > DW'(32'sh7FFFFFFF)) begin
          sy_o <= 32'sh7FFFFFFF;
        end else if (dfy_q < DW'(-33'sd2147483648)) begin
          sy_o <= 32'sh80000000;
        end else begin
          sy_o <= dfy_q[31:0];
        end
      end
    end
  end

  assign valid_o = v_q[NS-1];

endmodule

[hw/rtl/elliptical_lens_deflection.sv]
// Elliptical lens deflection: maps image-plane points to source-plane points
// through a singular isothermal ellipsoid lens.
// Input channel: point_x_i, point_y_i, last_point_i under in_valid_i/in_ready_o.
// Output channel: source_x_o, source_y_o, at_center_o, last_out_o under
// out_valid_o/out_ready_i. One transaction out for every transaction in, in order.
// Configuration channel: cfg_index_i selects the register, cfg_data_i carries the
// value; cfg_ready_o is always high. Write only while the pipeline is empty.
// The pipeline runs through offset, rotation and normalisation, then the
// one-bit-per-stage square root, then atanh range reduction, then the atan and
// atanh CORDIC rotators running side by side, and last scaling, back-rotation and
// saturation. Throughput is one point per cycle while the receiver is not stalling.
// Reset empties the pipeline and loads the default lens settings.
// When the receiver stalls with a result held, the whole pipeline freezes and
// in_ready_o drops; nothing is lost or repeated.
module elliptical_lens_deflection #(
  parameter int unsigned CORDIC_STAGES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic               last_point_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] source_x_o,
  output logic signed [31:0] source_y_o,
  output logic               at_center_o,
  output logic               last_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  eld_pkg::cfg_t cfg_q;
  logic          en;

  logic                   f_valid, s_valid, c_valid;
  eld_pkg::side_t         f_side, s_side, c_side;
  logic [eld_pkg::QW-1:0] f_q;
  logic [eld_pkg::PW-1:0] f_p1, f_p2, s_p1, s_p2;
  logic [eld_pkg::RW-1:0] s_r;
  logic signed [eld_pkg::ZW-1:0] c_zc, c_zh;

  // Advance whenever the output register is free or being taken
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // Lens settings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cx   <= '0;
      cfg_q.cy   <= '0;
      cfg_q.cosv <= 32'sd1073741824;
      cfg_q.sinv <= '0;
      cfg_q.f2   <= 30'd536870912;
      cfg_q.e    <= 31'd759250125;
      cfg_q.d    <= '0;
    end else if (cfg_valid_i) begin
      unique case (eld_pkg::cfg_idx_e'(cfg_index_i))
        eld_pkg::CFG_CENTER_X:      cfg_q.cx   <= cfg_data_i;
        eld_pkg::CFG_CENTER_Y:      cfg_q.cy   <= cfg_data_i;
        eld_pkg::CFG_COS_ANGLE:     cfg_q.cosv <= cfg_data_i;
        eld_pkg::CFG_SIN_ANGLE:     cfg_q.sinv <= cfg_data_i;
        eld_pkg::CFG_AXIS_RATIO_SQ: cfg_q.f2   <= cfg_data_i[29:0];
        eld_pkg::CFG_ELLIPTICITY:   cfg_q.e    <= cfg_data_i[30:0];
        eld_pkg::CFG_DEFL_SCALE:    cfg_q.d    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  eld_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .px_i    (point_x_i),
    .py_i    (point_y_i),
    .last_i  (last_point_i),
    .valid_o (f_valid),
    .side_o  (f_side),
    .q_o     (f_q),
    .p1_o    (f_p1),
    .p2_o    (f_p2)
  );

  eld_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .side_i  (f_side),
    .q_i     (f_q),
    .p1_i    (f_p1),
    .p2_i    (f_p2),
    .valid_o (s_valid),
    .side_o  (s_side),
    .r_o     (s_r),
    .p1_o    (s_p1),
    .p2_o    (s_p2)
  );

  eld_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .side_i  (s_side),
    .r_i     (s_r),
    .p1_i    (s_p1),
    .p2_i    (s_p2),
    .valid_o (c_valid),
    .side_o  (c_side),
    .zc_o    (c_zc),
    .zh_o    (c_zh)
  );

  eld_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .cfg_i    (cfg_q),
    .valid_i  (c_valid),
    .side_i   (c_side),
    .zc_i     (c_zc),
    .zh_i     (c_zh),
    .valid_o  (out_valid_o),
    .sx_o     (source_x_o),
    .sy_o     (source_y_o),
    .centre_o (at_center_o),
    .last_o   (last_out_o)
  );

endmodule
